[hdl/bppc_pkg.sv]
// Package for the button press plug controller.
// Holds register reset values, codes, and the structs shared by all modules.
// No dependencies.
package bppc_pkg;

  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned CfgIdxW          = 1;
  localparam int unsigned CfgDataW         = 16;
  localparam int unsigned HoldW            = 16;
  localparam int unsigned DebW             = 8;
  localparam int unsigned PressW           = 16;

  localparam logic [HoldW-1:0] HoldMsReset     = 16'd5000;
  localparam logic [DebW-1:0]  DebounceMsReset = 8'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_MS     = 1'b0,
    CFG_DEBOUNCE_MS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_PAIR  = 2'd2,
    EV_RESET = 2'd3
  } event_e;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'b0001,
    PH_PRESS_WAIT   = 4'b0010,
    PH_HELD         = 4'b0100,
    PH_RELEASE_WAIT = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [HoldW-1:0] hold_ms;
    logic [DebW-1:0]  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic command;
    logic button_level;
    logic paired;
    logic plug_value;
  } in_t;

endpackage

[hdl/bppc_if.sv]
// Valid/ready channel interfaces for the button press plug controller.
// Input beats, result beats and configuration writes; no dependencies.
interface bppc_in_if;
  logic valid;
  logic ready;
  logic command;
  logic button_level;
  logic paired;
  logic plug_value;

  modport source (output valid, command, button_level, paired, plug_value, input ready);
  modport sink   (input valid, command, button_level, paired, plug_value, output ready);
endinterface

interface bppc_out_if;
  logic        valid;
  logic        ready;
  logic        plug_on;
  logic        led_on;
  logic [1:0]  event_res;
  logic [15:0] press_ms;

  modport source (output valid, plug_on, led_on, event_res, press_ms, input ready);
  modport sink   (input valid, plug_on, led_on, event_res, press_ms, output ready);
endinterface

interface bppc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/button_press_plug_controller_top.sv]
// Top level of the button press plug controller.
// Depends on bppc_pkg, bppc_if, bppc_cfg_regs, bppc_in_stage and bppc_core.
//
//   Channel | Direction | Payload
//   in_i    | sink      | command, button_level, paired, plug_value
//   out_o   | source    | plug_on, led_on, event_res, press_ms
//   cfg_i   | sink      | index (0 hold_ms, 1 debounce_ms), data
//
// One beat in per cycle unless the result stalls; an accepted beat is held in the input
// register, then loaded into the result register, from which its result is taken.
// Sustained rate is one item per cycle while the result channel is not stalled.
// Reset puts the detector idle, the plug off, hold_ms 5000 and debounce_ms 50.
// A stalled result holds; the input register still takes one more beat.
// Configuration writes are always ready.
module button_press_plug_controller_top #(
  parameter int unsigned TimerBits = bppc_pkg::TimerBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bppc_in_if.sink    in_i,
  bppc_out_if.source out_o,
  bppc_cfg_if.sink   cfg_i
);
  import bppc_pkg::*;

  cfg_t cfg;
  in_t  item;
  logic item_valid;
  logic advance;

  bppc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bppc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  bppc_core #(
    .TimerBits (TimerBits)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_valid),
    .item_i    (item),
    .cfg_i     (cfg),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

[hdl/bppc_cfg_regs.sv]
// Configuration registers: hold time and debounce time.
// Depends on bppc_pkg and bppc_cfg_if.
module bppc_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  bppc_cfg_if.sink       cfg_i,
  output bppc_pkg::cfg_t cfg_o
);
  import bppc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_HOLD_MS:     cfg_d.hold_ms     = cfg_i.data[HoldW-1:0];
        CFG_DEBOUNCE_MS: cfg_d.debounce_ms = cfg_i.data[DebW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ms     <= HoldMsReset;
      cfg_q.debounce_ms <= DebounceMsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/bppc_in_stage.sv]
// Input register: captures one beat and holds it until the core takes it.
// Depends on bppc_pkg and bppc_in_if.
module bppc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  bppc_in_if.sink       in_i,
  input  logic          advance_i,
  output logic          valid_o,
  output bppc_pkg::in_t item_o
);
  import bppc_pkg::*;

  logic valid_q, valid_d;
  in_t  item_q, item_d;
  logic take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d             = 1'b1;
      item_d.command      = in_i.command;
      item_d.button_level = in_i.button_level;
      item_d.paired       = in_i.paired;
      item_d.plug_value   = in_i.plug_value;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hdl/bppc_core.sv]
// Press detector state machine, plug state and result register.
// Depends on bppc_pkg and bppc_out_if.
module bppc_core #(
  parameter int unsigned TimerBits = bppc_pkg::TimerBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  bppc_pkg::in_t  item_i,
  input  bppc_pkg::cfg_t cfg_i,
  output logic           advance_o,
  bppc_out_if.source     out_o
);
  import bppc_pkg::*;

  localparam int unsigned CmpW = (TimerBits > HoldW) ? TimerBits : HoldW;

  phase_e               phase_q, phase_d;
  logic [DebW-1:0]      deb_q, deb_d, deb_inc;
  logic [TimerBits-1:0] held_q, held_d, held_inc;
  logic                 long_done_q, long_done_d;
  logic                 plug_q, plug_d;

  logic                 out_valid_q, out_valid_d;
  event_e               ev_q, ev_d;
  logic [PressW-1:0]    pms_q, pms_d;

  logic                 fire;
  logic                 long_hit;
  logic                 deb_done;
  event_e               long_ev;
  logic [CmpW-1:0]      held_ext;

  assign advance_o = !out_valid_q || out_o.ready;
  assign fire      = valid_i && advance_o;

  // Both counters saturate instead of wrapping.
  assign deb_inc  = (deb_q == '1) ? deb_q : deb_q + 1'b1;
  assign held_inc = (held_q == '1) ? held_q : held_q + 1'b1;
  assign held_ext = CmpW'(held_inc);
  assign long_hit = held_ext >= CmpW'(cfg_i.hold_ms);
  assign deb_done = deb_inc >= cfg_i.debounce_ms;
  assign long_ev  = item_i.paired ? EV_RESET : EV_PAIR;

  always_comb begin
    phase_d     = phase_q;
    deb_d       = deb_q;
    held_d      = held_q;
    long_done_d = long_done_q;
    plug_d      = plug_q;
    ev_d        = EV_NONE;
    pms_d       = '0;

    if (item_i.command) begin
      plug_d = item_i.plug_value;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!item_i.button_level) begin
            if (cfg_i.debounce_ms == '0) begin
              phase_d     = PH_HELD;
              held_d      = '0;
              long_done_d = 1'b0;
            end else begin
              phase_d = PH_PRESS_WAIT;
              deb_d   = '0;
            end
          end
        end
        PH_PRESS_WAIT: begin
          deb_d = deb_inc;
          if (deb_done) begin
            if (!item_i.button_level) begin
              phase_d     = PH_HELD;
              held_d      = '0;
              long_done_d = 1'b0;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        PH_HELD: begin
          held_d = held_inc;
          if (!item_i.button_level) begin
            if (long_hit && !long_done_q) begin
              long_done_d = 1'b1;
              ev_d        = long_ev;
            end
          end else begin
            deb_d   = '0;
            phase_d = PH_RELEASE_WAIT;
            // With no debounce wait the release resolves on this tick.
            if (cfg_i.debounce_ms == '0) begin
              phase_d = PH_IDLE;
              if (!long_done_q) begin
                ev_d  = long_hit ? long_ev : EV_SHORT;
                pms_d = (held_ext > CmpW'({PressW{1'b1}})) ? '1 : held_ext[PressW-1:0];
                if (!long_hit) begin
                  plug_d = !plug_q;
                end
              end
            end
          end
        end
        PH_RELEASE_WAIT: begin
          held_d = held_inc;
          deb_d  = deb_inc;
          if (deb_done) begin
            if (item_i.button_level) begin
              phase_d = PH_IDLE;
              if (!long_done_q) begin
                ev_d  = long_hit ? long_ev : EV_SHORT;
                pms_d = (held_ext > CmpW'({PressW{1'b1}})) ? '1 : held_ext[PressW-1:0];
                if (!long_hit) begin
                  plug_d = !plug_q;
                end
              end
            end else begin
              phase_d = PH_HELD;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      deb_q       <= '0;
      held_q      <= '0;
      long_done_q <= 1'b0;
      plug_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q     <= phase_d;
        deb_q       <= deb_d;
        held_q      <= held_d;
        long_done_q <= long_done_d;
        plug_q      <= plug_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_q  <= ev_d;
      pms_q <= pms_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.plug_on   = plug_q;
  assign out_o.led_on    = !plug_q;
  assign out_o.event_res = ev_q;
  assign out_o.press_ms  = pms_q;

  a_fire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted item did not produce a result beat");

  a_press_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pms_q != '0) |-> (ev_q != EV_NONE))
    else $error("press duration reported without an event");

  a_short_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ev_d == EV_SHORT) |=> (plug_q != $past(plug_q)))
    else $error("short press did not toggle the plug");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> (plug_q == $past(plug_q) && phase_q == $past(phase_q)))
    else $error("state changed without an accepted item");

endmodule
